FILE: rtl/core/array_list_table_engine_defines.svh
// Assertion macros for the array list engine; clock clk, reset arst_n.
`ifndef ARRAY_LIST_TABLE_ENGINE_DEFINES_SVH
`define ARRAY_LIST_TABLE_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define ALTE_ASSERT_HOLD(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ALTE_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ALTE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ALTE_ASSERT_HOLD(label, prop, msg)
`define ALTE_ASSERT_IMPL(label, ante, cons, msg)
`define ALTE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: rtl/core/alte_pkg.sv
`default_nettype none

package alte_pkg;

	localparam int DEPTH     = 256;
	localparam int WORD_BITS = 32;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = ADDR_W + 1;

	localparam int ACTION_W = 3;
	localparam int INDEX_W  = 8;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 9;
	localparam int CAP_W    = 9;

	localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH   = 3'd0,
		ACT_POP    = 3'd1,
		ACT_REMOVE = 3'd2,
		ACT_GET    = 3'd3,
		ACT_SET    = 3'd4,
		ACT_FIND   = 3'd5
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_RANGE     = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef struct packed {
		action_t                    action;
		logic [INDEX_W-1:0]         index;
		logic signed [VALUE_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0]  read_value;
		logic [INDEX_W-1:0]         found_index;
		status_t                    status;
		logic [COUNT_W-1:0]         count;
	} rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/alte_store.sv
`default_nettype none

module alte_store (
	input  wire logic           clk,
	input  wire logic           we,
	input  alte_pkg::addr_t     waddr,
	input  alte_pkg::word_t     wdata,
	input  wire logic           re,
	input  alte_pkg::addr_t     raddr,
	output alte_pkg::word_t     rdata
);
	import alte_pkg::*;

	word_t mem_q [DEPTH];
	word_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/array_list_table_engine.sv
// Push, set and any rejected request: result strobed in the cycle after start.
// Pop and get: result strobed from S_FETCH, after one registered store read.
// Find walks from slot 0 to the first hit, remove from slot index+1 to the end; one store
// word is read and compared or moved per cycle, so the store walk sets the rate.
// busy is high until the result cycle; results cannot be stalled.
// Reset clears count, state and the capacity register (to 256); store is not cleared.
`default_nettype none
`include "array_list_table_engine_defines.svh"

module array_list_table_engine (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cap_we,
	input  wire logic [alte_pkg::CAP_W-1:0] cap_wdata,
	input  wire logic                     start,
	input  alte_pkg::req_t                req,
	output logic                          busy,
	output logic                          done,
	output alte_pkg::rsp_t                rsp
);
	import alte_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_FETCH = 3'b010,
		S_WALK  = 3'b100
	} state_t;

	state_t            state_q, state_d;
	cnt_t              count_q, count_d;
	logic [CAP_W-1:0]  cap_q;
	logic              done_q, fin;
	rsp_t              rsp_q, rsp_d;

	cnt_t              rd_ptr_q, rd_ptr_d;
	cnt_t              lim_q, lim_d;
	logic              find_q, find_d;
	logic              inflight_q, inflight_d;
	addr_t             daddr_q, daddr_d;
	word_t             key_q, key_d;

	logic              mem_we, mem_re;
	addr_t             mem_waddr, mem_raddr;
	word_t             mem_wdata, mem_rdata;

	logic              accept, full, idx_bad, hit, push_ok;
	cnt_t              idx_ext, cnt_dec;

	alte_store u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign accept  = start && !busy;
	assign idx_ext = {1'b0, req.index};
	assign cnt_dec = count_q - 1'b1;
	assign full    = (count_q >= cap_q) || (count_q >= CNT_W'(DEPTH));
	assign idx_bad = idx_ext >= count_q;
	assign push_ok = accept && (req.action == ACT_PUSH) && !full;
	// find: compares the registered store read with the key
	assign hit     = inflight_q && find_q && (mem_rdata == key_q);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		fin        = 1'b0;
		rsp_d      = rsp_q;
		rd_ptr_d   = rd_ptr_q;
		lim_d      = lim_q;
		find_d     = find_q;
		inflight_d = 1'b0;
		daddr_d    = daddr_q;
		key_d      = key_q;
		mem_we     = 1'b0;
		mem_waddr  = '0;
		mem_wdata  = '0;
		mem_re     = 1'b0;
		mem_raddr  = '0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					rsp_d.read_value  = '0;
					rsp_d.found_index = '0;
					rsp_d.status      = ST_OK;
					case (req.action)
						ACT_PUSH: begin
							fin = 1'b1;
							if (full) begin
								rsp_d.status = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = count_q[ADDR_W-1:0];
								mem_wdata = WORD_BITS'(req.value);
								count_d   = count_q + 1'b1;
							end
						end
						ACT_POP: begin
							if (count_q == '0) begin
								fin          = 1'b1;
								rsp_d.status = ST_EMPTY;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = cnt_dec[ADDR_W-1:0];
								count_d   = cnt_dec;
								state_d   = S_FETCH;
							end
						end
						ACT_REMOVE: begin
							if (idx_bad) begin
								fin          = 1'b1;
								rsp_d.status = ST_RANGE;
							end else begin
								count_d  = cnt_dec;
								rd_ptr_d = idx_ext + 1'b1;
								lim_d    = count_q;
								find_d   = 1'b0;
								state_d  = S_WALK;
							end
						end
						ACT_GET: begin
							if (idx_bad) begin
								fin          = 1'b1;
								rsp_d.status = ST_RANGE;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = req.index[ADDR_W-1:0];
								state_d   = S_FETCH;
							end
						end
						ACT_SET: begin
							fin = 1'b1;
							if (idx_bad) begin
								rsp_d.status = ST_RANGE;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = req.index[ADDR_W-1:0];
								mem_wdata = WORD_BITS'(req.value);
							end
						end
						ACT_FIND: begin
							rd_ptr_d = '0;
							lim_d    = count_q;
							find_d   = 1'b1;
							key_d    = WORD_BITS'(req.value);
							state_d  = S_WALK;
						end
						default: begin
							fin = 1'b1;
						end
					endcase
					rsp_d.count = COUNT_W'(count_d);
				end
			end
			S_FETCH: begin
				fin               = 1'b1;
				rsp_d.read_value  = VALUE_W'(mem_rdata);
				rsp_d.found_index = '0;
				rsp_d.status      = ST_OK;
				rsp_d.count       = COUNT_W'(count_q);
				state_d           = S_IDLE;
			end
			S_WALK: begin
				rsp_d.read_value  = '0;
				rsp_d.found_index = '0;
				rsp_d.status      = ST_OK;
				rsp_d.count       = COUNT_W'(count_q);
				// remove: word read last cycle moves down one slot
				if (inflight_q && !find_q) begin
					mem_we    = 1'b1;
					mem_waddr = daddr_q - 1'b1;
					mem_wdata = mem_rdata;
				end
				if (hit) begin
					fin               = 1'b1;
					rsp_d.found_index = INDEX_W'(daddr_q);
					state_d           = S_IDLE;
				end else if (rd_ptr_q < lim_q) begin
					mem_re     = 1'b1;
					mem_raddr  = rd_ptr_q[ADDR_W-1:0];
					inflight_d = 1'b1;
					daddr_d    = rd_ptr_q[ADDR_W-1:0];
					rd_ptr_d   = rd_ptr_q + 1'b1;
				end else begin
					fin = 1'b1;
					if (find_q) begin
						rsp_d.status = ST_NOT_FOUND;
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			cap_q      <= CAP_RESET;
			done_q     <= 1'b0;
			rd_ptr_q   <= '0;
			lim_q      <= '0;
			find_q     <= 1'b0;
			inflight_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			done_q     <= fin;
			rd_ptr_q   <= rd_ptr_d;
			lim_q      <= lim_d;
			find_q     <= find_d;
			inflight_q <= inflight_d;
			if (cap_we) begin
				cap_q <= cap_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		rsp_q   <= rsp_d;
		daddr_q <= daddr_d;
		key_q   <= key_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	`ALTE_ASSERT_HOLD(a_count_max, count_q <= CNT_W'(DEPTH), "count above depth")
	`ALTE_ASSERT_IMPL(a_done_idle, done_q, !busy, "result strobed while busy")
	`ALTE_ASSERT_IMPL(a_done_cause, done_q, $past(accept) || $past(state_q != S_IDLE), "stray result")
	`ALTE_ASSERT_NEXT(a_push_count, push_ok, count_q == $past(count_q) + 1'b1, "push lost count")

endmodule

`default_nettype wire
